/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg - shared types and codes for the stable priority queue
// Operation and status codes, default sizes and the word types of both
// channels and of the control word sent down the row of cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default sizes
  localparam int CAPACITY_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  // fixed field widths
  localparam int VALUE_W    = 32;
  localparam int PRIO_IN_W  = 8;
  localparam int COUNT_OUT_W = 5;

  // operation codes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // command word
  typedef struct packed {
    logic [1:0]                  operation;
    logic signed [VALUE_W-1:0]   item_value;
    logic [PRIO_IN_W-1:0]        item_priority;
  } request_t;

  // result word
  typedef struct packed {
    logic [1:0]                  status;
    logic signed [VALUE_W-1:0]   removed_value;
    logic signed [VALUE_W-1:0]   head_value;
    logic [COUNT_OUT_W-1:0]      entry_count;
    logic                        is_empty;
    logic                        is_full;
  } response_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                        clear;
    logic                        shift_out;
    logic                        insert;
    logic [VALUE_W-1:0]          value;
  } cell_ctrl_t;

endpackage

/* rtl/stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue - bounded sorted queue, lowest priority number first
// Row of slot cells kept in sorted order, head in slot 0; equal priorities
// leave in arrival order. Enqueue, dequeue or clear, one word per command.
// ----------------------------------------------------------------------------
//  channel   ports                  handshake
//  command   request                taken when start is high and busy is low
//  result    response               valid for the one cycle done is high
//
//  For every command all cells compare against the new priority at once and
//  shift or load in the same edge; its result is shown in the following
//  cycle, so a command may be issued every cycle and busy stays low.
//  Reset empties the queue. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::request_t  request,
  output logic               done,
  output spq_pkg::response_t response
);
  import spq_pkg::*;

  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  logic                      accept;
  logic [COUNT_W-1:0]        count;
  logic                      empty_now;
  logic                      full_now;
  logic [PRIORITY_BITS+PRIO_IN_W-1:0] prio_wide;
  logic [PRIORITY_BITS-1:0]  new_prio;
  cell_ctrl_t                ctrl;
  logic [1:0]                status;
  logic [VALUE_W-1:0]        removed;
  logic [COUNT_W+COUNT_OUT_W-1:0] count_wide;

  logic [CAPACITY-1:0]       keep;
  logic [CAPACITY-1:0]       used;
  logic [VALUE_W-1:0]        value [CAPACITY];
  logic [PRIORITY_BITS-1:0]  prio  [CAPACITY];

  // commands never stall: always ready
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign empty_now = (count == '0);
  assign full_now  = (count == CAP_COUNT);

  // keep the low priority bits
  assign prio_wide = {{PRIORITY_BITS{1'b0}}, request.item_priority};
  assign new_prio  = prio_wide[PRIORITY_BITS-1:0];

  // broadcast control to the row
  always_comb begin
    ctrl.clear     = accept && (request.operation == OP_CLEAR);
    ctrl.shift_out = accept && (request.operation == OP_DEQUEUE) && !empty_now;
    ctrl.insert    = accept && (request.operation == OP_ENQUEUE) && !full_now;
    ctrl.value     = request.item_value;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     l_keep;
    logic                     l_used;
    logic [VALUE_W-1:0]       l_value;
    logic [PRIORITY_BITS-1:0] l_prio;
    logic                     r_used;
    logic [VALUE_W-1:0]       r_value;
    logic [PRIORITY_BITS-1:0] r_prio;

    if (i == 0) begin : g_head
      assign l_keep  = 1'b1;
      assign l_used  = 1'b0;
      assign l_value = '0;
      assign l_prio  = '0;
    end else begin : g_body
      assign l_keep  = keep[i-1];
      assign l_used  = used[i-1];
      assign l_value = value[i-1];
      assign l_prio  = prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_used  = 1'b0;
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_mid
      assign r_used  = used[i+1];
      assign r_value = value[i+1];
      assign r_prio  = prio[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_prio    (new_prio),
      .left_keep   (l_keep),
      .left_used   (l_used),
      .left_value  (l_value),
      .left_prio   (l_prio),
      .right_used  (r_used),
      .right_value (r_value),
      .right_prio  (r_prio),
      .keep        (keep[i]),
      .used        (used[i]),
      .value       (value[i]),
      .prio        (prio[i])
    );
  end

  // entry count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (ctrl.clear) begin
        count <= '0;
      end else if (ctrl.shift_out) begin
        count <= count - 1'b1;
      end else if (ctrl.insert) begin
        count <= count + 1'b1;
      end
    end
  end

  // capture status and removed head
  always_ff @(posedge clk) begin
    if (accept) begin
      status  <= ST_OK;
      removed <= '0;
      if (request.operation == OP_DEQUEUE) begin
        if (empty_now) begin
          status <= ST_EMPTY;
        end else begin
          removed <= value[0];
        end
      end else if (request.operation == OP_ENQUEUE && full_now) begin
        status <= ST_FULL;
      end
    end
  end

  // assemble result word from the updated row
  assign count_wide = {{COUNT_OUT_W{1'b0}}, count};

  always_comb begin
    response.status        = status;
    response.removed_value = removed;
    response.head_value    = used[0] ? value[0] : '0;
    response.entry_count   = count_wide[COUNT_OUT_W-1:0];
    response.is_empty      = empty_now;
    response.is_full       = full_now;
  end

endmodule

/* rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted queue
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbor's; on dequeue it takes its right neighbor's; clear empties it.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  logic [PRIORITY_BITS-1:0]   new_prio,
  input  logic                       left_keep,
  input  logic                       left_used,
  input  logic [spq_pkg::VALUE_W-1:0] left_value,
  input  logic [PRIORITY_BITS-1:0]   left_prio,
  input  logic                       right_used,
  input  logic [spq_pkg::VALUE_W-1:0] right_value,
  input  logic [PRIORITY_BITS-1:0]   right_prio,
  output logic                       keep,
  output logic                       used,
  output logic [spq_pkg::VALUE_W-1:0] value,
  output logic [PRIORITY_BITS-1:0]   prio
);
  import spq_pkg::*;

  // stay in place when the new entry belongs behind this one
  assign keep = used && (prio <= new_prio);

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.clear) begin
      used <= 1'b0;
    end else if (ctrl.shift_out) begin
      used <= right_used;
    end else if (ctrl.insert && !keep) begin
      used <= left_keep ? 1'b1 : left_used;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (ctrl.shift_out) begin
      value <= right_value;
      prio  <= right_prio;
    end else if (ctrl.insert && !keep) begin
      if (left_keep) begin
        value <= ctrl.value;
        prio  <= new_prio;
      end else begin
        value <= left_value;
        prio  <= left_prio;
      end
    end
  end

endmodule
